/* rtl/core/spq_pkg.sv */
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

   // Operation codes of a request
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Status codes of a response
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;
   localparam int OCC_W   = 5;

   // One stored entry: value and signed Q8.8 priority
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } entry_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic      insert;
      logic      delete;
      entry_type fresh;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* rtl/core/spq_if.sv */
// Request and response channel interfaces of the sorted priority queue.
`default_nettype none
interface spq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] item_value;
   logic [15:0] item_priority;

   modport source (output valid, operation, item_value, item_priority, input ready);
   modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_value;
   logic [15:0] out_priority;
   logic [4:0]  occupancy;

   modport source (output valid, status, out_value, out_priority, occupancy, input ready);
   modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface
`default_nettype wire

/* rtl/core/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell #(
   parameter int CNT_W = 5,
   parameter int IDX   = 0
) (
   input  wire                        clock,
   input  wire spq_pkg::cell_ctl_type ctl,
   input  wire [CNT_W-1:0]            count,
   input  wire spq_pkg::entry_type    left_entry,
   input  wire                        left_keep,
   input  wire spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type         entry,
   output logic                       keep
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   // Slot holds a live entry that ranks at or above the new one
   assign occupied = count > CNT_W'(IDX);
   assign keep     = occupied && (entry_ff.prio >= ctl.fresh.prio);

   // Insert: stay, take the new entry, or shift right; delete: shift left
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && !keep) begin
         entry_in = left_keep ? ctl.fresh : left_entry;
      end else if (ctl.delete) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
// Top level of the sorted priority queue: cell chain, count and response register.
//
//   Channel | Direction | Payload
//   req     | in        | operation, item_value, item_priority
//   rsp     | out       | status, out_value, out_priority, occupancy
//
// All cells compare against the new priority in parallel and shift in the same
// clock edge, so one request per cycle while the response is not stalled.
// The response sits in an output register; a new request is taken whenever
// that register is empty or being drained in the same cycle.
// Synchronous reset empties the queue (count to zero) and drops the response.
`default_nettype none
module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input wire          clock,
   input wire          reset,
   spq_req_if.sink     req,
   spq_rsp_if.source   rsp
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   status_type       status_ff;
   status_type       status_in;
   entry_type        out_ff;
   entry_type        out_in;

   logic             accept;
   logic             is_full;
   logic             is_empty;
   op_type           op;
   cell_ctl_type     ctl;
   entry_type        cell_entry [CAPACITY];
   logic             cell_keep  [CAPACITY];

   assign op       = op_type'(req.operation);
   assign is_full  = count_ff == CNT_W'(CAPACITY);
   assign is_empty = count_ff == '0;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept   = req.valid && req.ready;

   // Control broadcast to the cells
   always_comb begin
      ctl.fresh.value = req.item_value;
      ctl.fresh.prio  = req.item_priority;
      ctl.insert      = accept && (op == OP_INSERT) && !is_full;
      ctl.delete      = accept && (op == OP_DELETE) && !is_empty;
   end

   // Cell chain, slot 0 is the front
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;
      if (i == 0) begin : g_head
         assign left_entry = ctl.fresh;
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end
      spq_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   // Count and response next values
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      out_in    = '0;
      case (op)
         OP_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               out_in   = cell_entry[0];
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         out_ff    <= out_in;
      end
   end

   logic [CNT_W-1:0] occ_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         occ_ff <= count_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.out_value    = out_ff.value;
   assign rsp.out_priority = out_ff.prio;
   assign rsp.occupancy    = OCC_W'(occ_ff);

`ifndef SYNTHESIS
   // Count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // Insert into a non-full queue grows the count by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");

   // Delete from a non-empty queue answers success next cycle
   a_delete_ok: assert property (@(posedge clock) disable iff (reset)
      ctl.delete |=> rsp_valid_ff && status_ff == ST_OK)
      else $error("delete did not report success");

   // Front two entries stay in descending priority order
   a_front_order: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> cell_entry[0].prio >= cell_entry[1].prio)
      else $error("front entries out of order");

   // A request is never taken while a stalled response is held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !accept)
      else $error("request accepted over a stalled response");
`endif

endmodule
`default_nettype wire
